@@ rtl/cltw_pkg.sv @@
// shared types and constants for the cyclic linear tween block
`timescale 1ns / 1ps

package cltw_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_JUMP = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TOTAL     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SNAP_TOLERANCE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CYCLIC_MODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_DIR    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH     = 3'd5;

  localparam int TOL_WIDTH = 30;

  // reset values of the configuration registers
  localparam int STEP_TOTAL_RESET = 16;
  localparam int RANGE_HIGH_RESET = 23592960;

  typedef struct packed {
    logic cyclic;
    logic forward;
  } cfg_mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/cltw_cfg.sv @@
// configuration register file of the cyclic linear tween block
`timescale 1ns / 1ps

module cltw_cfg #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 wr_en,
  input  logic [cltw_pkg::CFG_INDEX_W-1:0]                     wr_index,
  input  logic [((VALUE_WIDTH > 30) ? VALUE_WIDTH : 30)-1:0]   wr_data,
  output logic [COUNT_WIDTH-1:0]                               step_total,
  output logic [cltw_pkg::TOL_WIDTH-1:0]                       snap_tolerance,
  output cltw_pkg::cfg_mode_t                                  mode,
  output logic signed [VALUE_WIDTH-1:0]                        range_low,
  output logic signed [VALUE_WIDTH-1:0]                        range_high
);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total     <= COUNT_WIDTH'(cltw_pkg::STEP_TOTAL_RESET);
      snap_tolerance <= '0;
      mode.cyclic    <= 1'b0;
      mode.forward   <= 1'b1;
      range_low      <= '0;
      range_high     <= VALUE_WIDTH'(cltw_pkg::RANGE_HIGH_RESET);
    end else if (wr_en) begin
      case (wr_index)
        cltw_pkg::CFG_STEP_TOTAL:     step_total     <= wr_data[COUNT_WIDTH-1:0];
        cltw_pkg::CFG_SNAP_TOLERANCE: snap_tolerance <= wr_data[cltw_pkg::TOL_WIDTH-1:0];
        cltw_pkg::CFG_CYCLIC_MODE:    mode.cyclic    <= wr_data[0];
        cltw_pkg::CFG_FORWARD_DIR:    mode.forward   <= wr_data[0];
        cltw_pkg::CFG_RANGE_LOW:      range_low      <= wr_data[VALUE_WIDTH-1:0];
        cltw_pkg::CFG_RANGE_HIGH:     range_high     <= wr_data[VALUE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/cltw_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module cltw_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [VALUE_WIDTH+COUNT_WIDTH:0]       dividend,
  input  logic [COUNT_WIDTH-1:0]                 divisor,
  output logic [VALUE_WIDTH:0]                   quotient,
  output cltw_pkg::div_stat_t                    stat
);

  localparam int NQ  = VALUE_WIDTH + 1;
  localparam int ITW = $clog2(NQ + 1);

  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dvs;
  logic [NQ-1:0]          qs;
  logic [ITW-1:0]         cnt;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   trial_sub;
  logic                   ge;

  // the quotient never exceeds NQ bits, so the top bits seed the remainder
  always_comb begin
    trial     = {rem, qs[NQ-1]};
    ge        = trial >= {1'b0, dvs};
    trial_sub = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == ITW'(NQ - 1));
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
        rem       <= dividend[VALUE_WIDTH+COUNT_WIDTH:NQ];
        qs        <= dividend[NQ-1:0];
        dvs       <= divisor;
      end else if (stat.busy) begin
        rem <= ge ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
        qs  <= {qs[NQ-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == ITW'(NQ - 1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = qs;

endmodule

@@ rtl/cyclic_linear_tween.sv @@
// cyclic linear tween: a ramping tick steps through prep, diff, mul and div, then sat, with
// wrap_hi and wrap_lo before sat when the value wraps into the range; the longest step is
// the divider loop of VALUE_WIDTH + 1 steps; its result is loaded in the output state
// set, jump and ticks of a finished ramp go from accept straight to the output state
// one item is in work at a time; the next is taken the cycle after the result is loaded
// synchronous reset clears the values to zero and marks the ramp done; config registers reset
`timescale 1ns / 1ps

module cyclic_linear_tween #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [1:0]                                         operation,
  input  logic signed [VALUE_WIDTH-1:0]                      new_value,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic signed [VALUE_WIDTH-1:0]                      current_value,
  output logic                                               ramp_done,
  input  logic                                               cfg_valid,
  output logic                                               cfg_ready,
  input  logic [cltw_pkg::CFG_INDEX_W-1:0]                   cfg_index,
  input  logic [((VALUE_WIDTH > 30) ? VALUE_WIDTH : 30)-1:0] cfg_data
);

  localparam int W   = VALUE_WIDTH;
  localparam int VW  = VALUE_WIDTH + 3;
  localparam int DVW = VALUE_WIDTH + COUNT_WIDTH + 1;
  localparam int EW  = (W + 1 > cltw_pkg::TOL_WIDTH + 1) ? W + 1 : cltw_pkg::TOL_WIDTH + 1;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIFF, ST_MUL, ST_DIV, ST_WRAP_HI, ST_WRAP_LO, ST_SAT, ST_OUT
  } state_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [VW-1:0] v);
    logic signed [W-1:0] r;
    if (v > VW'(VMAX)) r = VMAX;
    else if (v < VW'(VMIN)) r = VMIN;
    else r = v[W-1:0];
    return r;
  endfunction

  logic [COUNT_WIDTH-1:0]           step_total;
  logic [cltw_pkg::TOL_WIDTH-1:0]   snap_tolerance;
  cltw_pkg::cfg_mode_t              mode;
  logic signed [W-1:0]              range_low;
  logic signed [W-1:0]              range_high;

  state_t                  state;
  logic signed [W-1:0]     target_value;
  logic signed [W-1:0]     start_value;
  logic signed [W-1:0]     present_value;
  logic [COUNT_WIDTH-1:0]  step_count;
  logic signed [W-1:0]     eff;
  logic                    wrap;
  logic                    neg;
  logic [W:0]              mag;
  logic [COUNT_WIDTH-1:0]  k;
  logic [DVW-1:0]          prod;
  logic signed [VW-1:0]    vwork;
  logic                    div_start;

  logic [W:0]              quotient;
  cltw_pkg::div_stat_t     div_stat;

  logic                    is_done;
  logic signed [VW-1:0]    span_w;
  logic                    direct;
  logic signed [VW-1:0]    eff_w;
  logic signed [W:0]       diff_w;
  logic signed [W:0]       d_snap;
  logic [W:0]              dmag;
  logic                    near;
  logic                    snap;
  logic signed [VW-1:0]    q_ext;
  logic signed [VW-1:0]    v_ramp;

  cltw_cfg #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (cfg_valid),
    .wr_index       (cfg_index),
    .wr_data        (cfg_data),
    .step_total     (step_total),
    .snap_tolerance (snap_tolerance),
    .mode           (mode),
    .range_low      (range_low),
    .range_high     (range_high)
  );

  cltw_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (step_total),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    is_done = step_count >= step_total;
    span_w  = VW'(range_high) - VW'(range_low);
    direct  = mode.forward ? (start_value < target_value) : (start_value > target_value);
    eff_w   = mode.forward ? VW'(target_value) + span_w : VW'(target_value) - span_w;
    diff_w  = (W+1)'(eff) - (W+1)'(start_value);
    d_snap  = (W+1)'(present_value) - (W+1)'(new_value);
    dmag    = d_snap[W] ? -d_snap : d_snap;
    near    = EW'(dmag) < EW'({snap_tolerance, 1'b0});
    // in cyclic mode only a target behind the current one may snap
    if (!mode.cyclic) snap = near;
    else if (mode.forward) snap = (new_value < target_value) && near;
    else snap = (new_value > target_value) && near;
    q_ext   = {{(VW-W-1){1'b0}}, quotient};
    v_ramp  = neg ? VW'(start_value) - q_ext : VW'(start_value) + q_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      target_value  <= '0;
      start_value   <= '0;
      present_value <= '0;
      step_count    <= COUNT_WIDTH'(cltw_pkg::STEP_TOTAL_RESET);
      div_start     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      div_start <= (state == ST_MUL);
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (operation)
              cltw_pkg::OP_TICK: begin
                if (is_done) begin
                  present_value <= target_value;
                  state         <= ST_OUT;
                end else begin
                  state <= ST_PREP;
                end
              end
              cltw_pkg::OP_SET: begin
                if (snap) begin
                  start_value   <= new_value;
                  present_value <= new_value;
                  target_value  <= new_value;
                  step_count    <= step_total;
                end else begin
                  start_value  <= present_value;
                  target_value <= new_value;
                  step_count   <= '0;
                end
                state <= ST_OUT;
              end
              cltw_pkg::OP_JUMP: begin
                start_value   <= new_value;
                present_value <= new_value;
                target_value  <= new_value;
                step_count    <= step_total;
                state         <= ST_OUT;
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_PREP: begin
          // going the long way round aims one span past the target
          wrap <= mode.cyclic && !direct;
          eff  <= (mode.cyclic && !direct) ? sat_w(eff_w) : target_value;
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          neg   <= diff_w[W];
          mag   <= diff_w[W] ? -diff_w : diff_w;
          k     <= step_count + 1'b1;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod      <= mag * k;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            vwork <= v_ramp;
            state <= wrap ? ST_WRAP_HI : ST_SAT;
          end
        end
        ST_WRAP_HI: begin
          if (vwork > VW'(range_high)) vwork <= vwork - span_w;
          state <= ST_WRAP_LO;
        end
        ST_WRAP_LO: begin
          if (vwork < VW'(range_low)) vwork <= vwork + span_w;
          state <= ST_SAT;
        end
        ST_SAT: begin
          present_value <= sat_w(vwork);
          step_count    <= step_count + 1'b1;
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            current_value <= present_value;
            ramp_done     <= is_done;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == ST_DIV) && !div_stat.busy)
    else $error("divider started while busy or out of sequence");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while an item is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || out_ready)) |=> out_valid && in_ready)
    else $error("result not presented when the output register was free");

endmodule
